// ===== sv/que_pkg.sv =====
// Package for the quadratic utility evaluator: payload types, mode codes, defaults.
package que_pkg;

  localparam int DEF_GOODS = 16;

  localparam logic [2:0] MODE_WR_LIN  = 3'd0;
  localparam logic [2:0] MODE_WR_QUAD = 3'd1;
  localparam logic [2:0] MODE_SET_QTY = 3'd2;
  localparam logic [2:0] MODE_CLR_BUN = 3'd3;
  localparam logic [2:0] MODE_UTIL    = 3'd4;
  localparam logic [2:0] MODE_DER1    = 3'd5;
  localparam logic [2:0] MODE_DER2    = 3'd6;

  typedef struct packed {
    logic [2:0]         mode;
    logic [3:0]         good_a;
    logic [3:0]         good_b;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [47:0] result;
    logic               saturated;
  } out_t;

endpackage

// ===== sv/que_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module que_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/quadratic_utility_evaluator_unit.sv =====
// Top level of the quadratic utility evaluator: sequencer, tables and MAC pipeline.
//
// Usage: after reset the block is busy while a clearing pass zeroes the
// coefficient tables. An item is taken when start is high and busy is low.
// Table writes, quantity writes and bundle clears leave the block idle. A utility
// request issues one multiply-accumulate term per cycle from the offset and the
// linear and quadratic tables, 1 + GOODS + GOODS*(GOODS+1)/2 terms, then drains
// the pipeline, rounds and outputs. A first derivative issues a linear term and
// one quadratic term per good, a second derivative a single quadratic term.
// Each result appears on out_item for exactly one cycle with out_valid high; the
// receiver cannot stall it. The offset register may be written through the cfg
// channel while the block is idle; cfg_ready is always high.
module quadratic_utility_evaluator_unit
  import que_pkg::*;
#(
  parameter int GOODS = DEF_GOODS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_t                in_item,
  output logic               out_valid,
  output out_t               out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [31:0] cfg_data
);

  localparam int IW = $clog2(GOODS);
  localparam int QD = GOODS * GOODS;
  localparam int AW = $clog2(QD);
  localparam logic [IW-1:0] IMAX = IW'(GOODS - 1);
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] TWO = 32'sh0002_0000;
  localparam logic signed [127:0] HALF = 128'sh8000_0000;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RUN, ST_DRAIN, ST_ROUND, ST_FIN
  } state_t;

  typedef enum logic [1:0] {CS_OFF, CS_LIN, CS_QUAD} coef_sel_t;
  typedef enum logic [1:0] {YS_QB, YS_ONE, YS_TWO} y_sel_t;

  // control registers
  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [2:0]         mode_r, mode_nxt;
  logic [3:0]         a_r, a_nxt;
  logic [3:0]         b_r, b_nxt;
  logic               first_r, first_nxt;
  logic               lin_ph_r, lin_ph_nxt;
  logic [IW-1:0]      i_r, i_nxt;
  logic [IW-1:0]      j_r, j_nxt;
  logic [GOODS-1:0]   qv_r, qv_nxt;
  logic signed [31:0] offset_r, offset_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_item_r, out_item_nxt;
  logic               s1_v_r, s2_v_r, s3_v_r, s4_v_r;

  // datapath registers
  coef_sel_t          s1_csel_r;
  logic               s1_xqa_r;
  y_sel_t             s1_ysel_r;
  logic               s1_zero_r;
  logic [IW-1:0]      s1_qa_r, s1_qb_r;
  logic signed [63:0] p1_r;
  logic signed [31:0] y_r;
  logic signed [64:0] pl_r;
  logic signed [63:0] ph_r;
  logic signed [127:0] term_r, acc_r, sum_r;

  // issue signals
  logic          iss_v, iss_last, iss_xqa, iss_zero;
  coef_sel_t     iss_csel;
  y_sel_t        iss_ysel;
  logic [IW-1:0] lin_ra, qa_ra, qb_ra;
  logic [AW-1:0] quad_ra;

  // write port signals
  logic          lin_we, quad_we, qty_we;
  logic [IW-1:0] lin_wa, qty_wa;
  logic [AW-1:0] quad_wa;
  logic [31:0]   lin_wd, quad_wd, qty_wd;

  logic [31:0] lin_rd, quad_rd, qa_rd, qb_rd;

  logic          in_fire, in_a_ok, in_b_ok, ar_ok, br_ok, acc_clr;
  logic [IW-1:0] in_ai, in_bi, ai, bi;

  function automatic logic [AW-1:0] qaddr(input logic [IW-1:0] x, input logic [IW-1:0] y);
    logic [IW-1:0] row;
    logic [IW-1:0] col;
    row = (x < y) ? x : y;
    col = (x < y) ? y : x;
    return AW'(AW'(row) * AW'(GOODS) + AW'(col));
  endfunction

  assign busy      = (state_r != ST_IDLE);
  assign in_fire   = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign in_a_ok = (32'(in_item.good_a) < 32'(GOODS));
  assign in_b_ok = (32'(in_item.good_b) < 32'(GOODS));
  assign ar_ok   = (32'(a_r) < 32'(GOODS));
  assign br_ok   = (32'(b_r) < 32'(GOODS));
  assign in_ai   = IW'(in_item.good_a);
  assign in_bi   = IW'(in_item.good_b);
  assign ai      = IW'(a_r);
  assign bi      = IW'(b_r);
  assign acc_clr = in_fire && (in_item.mode == MODE_UTIL || in_item.mode == MODE_DER1 ||
                               in_item.mode == MODE_DER2);

  // table memories; two quantity copies give two read ports
  que_ram #(.WIDTH(32), .DEPTH(GOODS)) u_lin (
    .clk(clk), .we(lin_we), .waddr(lin_wa), .wdata(lin_wd), .raddr(lin_ra), .rdata(lin_rd)
  );
  que_ram #(.WIDTH(32), .DEPTH(QD)) u_quad (
    .clk(clk), .we(quad_we), .waddr(quad_wa), .wdata(quad_wd), .raddr(quad_ra),
    .rdata(quad_rd)
  );
  que_ram #(.WIDTH(32), .DEPTH(GOODS)) u_qty_a (
    .clk(clk), .we(qty_we), .waddr(qty_wa), .wdata(qty_wd), .raddr(qa_ra), .rdata(qa_rd)
  );
  que_ram #(.WIDTH(32), .DEPTH(GOODS)) u_qty_b (
    .clk(clk), .we(qty_we), .waddr(qty_wa), .wdata(qty_wd), .raddr(qb_ra), .rdata(qb_rd)
  );

  // drive table writes from the clearing pass or an accepted write item
  always_comb begin
    lin_we  = 1'b0;
    lin_wa  = in_ai;
    lin_wd  = in_item.value;
    quad_we = 1'b0;
    quad_wa = qaddr(in_ai, in_bi);
    quad_wd = in_item.value;
    qty_we  = 1'b0;
    qty_wa  = in_ai;
    qty_wd  = in_item.value;
    if (state_r == ST_CLEAR) begin
      quad_we = 1'b1;
      quad_wa = clr_r;
      quad_wd = '0;
      lin_we  = (32'(clr_r) < 32'(GOODS));
      lin_wa  = IW'(clr_r);
      lin_wd  = '0;
    end else if (in_fire) begin
      case (in_item.mode)
        MODE_WR_LIN:  lin_we  = in_a_ok;
        MODE_WR_QUAD: quad_we = in_a_ok && in_b_ok;
        MODE_SET_QTY: qty_we  = in_a_ok;
        default: ;
      endcase
    end
  end

  // pick the term to issue this cycle
  always_comb begin
    iss_v    = 1'b0;
    iss_last = 1'b0;
    iss_csel = CS_QUAD;
    iss_xqa  = 1'b0;
    iss_ysel = YS_ONE;
    iss_zero = 1'b0;
    lin_ra   = '0;
    quad_ra  = '0;
    qa_ra    = '0;
    qb_ra    = '0;
    if (state_r == ST_RUN) begin
      iss_v = 1'b1;
      case (mode_r)
        MODE_UTIL: begin
          if (first_r) begin
            iss_csel = CS_OFF;
          end else if (lin_ph_r) begin
            iss_csel = CS_LIN;
            lin_ra   = i_r;
            iss_xqa  = 1'b1;
            qa_ra    = i_r;
          end else begin
            quad_ra  = qaddr(i_r, j_r);
            iss_xqa  = 1'b1;
            qa_ra    = i_r;
            iss_ysel = YS_QB;
            qb_ra    = j_r;
            iss_last = (i_r == IMAX) && (j_r == IMAX);
          end
        end
        MODE_DER1: begin
          iss_zero = !ar_ok;
          if (first_r) begin
            iss_csel = CS_LIN;
            lin_ra   = ai;
          end else begin
            quad_ra  = qaddr(ai, j_r);
            iss_xqa  = 1'b1;
            qa_ra    = j_r;
            iss_ysel = (j_r == ai) ? YS_TWO : YS_ONE;
            iss_last = (j_r == IMAX);
          end
        end
        MODE_DER2: begin
          iss_zero = !(ar_ok && br_ok);
          quad_ra  = qaddr(ai, bi);
          iss_ysel = (a_r == b_r) ? YS_TWO : YS_ONE;
          iss_last = 1'b1;
        end
        default: iss_last = 1'b1;
      endcase
    end
  end

  // next-state logic for the sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    mode_nxt      = mode_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    first_nxt     = first_r;
    lin_ph_nxt    = lin_ph_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    qv_nxt        = qv_r;
    offset_nxt    = offset_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    if (cfg_valid && cfg_ready) begin
      offset_nxt = cfg_data;
    end
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(QD - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          mode_nxt  = in_item.mode;
          a_nxt     = in_item.good_a;
          b_nxt     = in_item.good_b;
          first_nxt = 1'b1;
          case (in_item.mode)
            MODE_SET_QTY: if (in_a_ok) qv_nxt[in_ai] = 1'b1;
            MODE_CLR_BUN: qv_nxt = '0;
            MODE_UTIL, MODE_DER1, MODE_DER2: state_nxt = ST_RUN;
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        case (mode_r)
          MODE_UTIL: begin
            if (first_r) begin
              first_nxt  = 1'b0;
              lin_ph_nxt = 1'b1;
              i_nxt      = '0;
            end else if (lin_ph_r) begin
              lin_ph_nxt = 1'b0;
              j_nxt      = i_r;
            end else if (j_r == IMAX) begin
              if (i_r != IMAX) begin
                i_nxt      = i_r + IW'(1);
                lin_ph_nxt = 1'b1;
              end
            end else begin
              j_nxt = j_r + IW'(1);
            end
          end
          MODE_DER1: begin
            if (first_r) begin
              first_nxt = 1'b0;
              j_nxt     = '0;
            end else if (j_r != IMAX) begin
              j_nxt = j_r + IW'(1);
            end
          end
          default: ;
        endcase
        if (iss_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!(s1_v_r || s2_v_r || s3_v_r || s4_v_r)) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: state_nxt = ST_FIN;
      ST_FIN: begin
        out_valid_nxt = 1'b1;
        if (sum_r[127:79] == {49{sum_r[127]}}) begin
          out_item_nxt.result    = sum_r[79:32];
          out_item_nxt.saturated = 1'b0;
        end else begin
          out_item_nxt.result    = sum_r[127] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
          out_item_nxt.saturated = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      mode_r      <= MODE_WR_LIN;
      a_r         <= '0;
      b_r         <= '0;
      first_r     <= 1'b0;
      lin_ph_r    <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      qv_r        <= '0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      mode_r      <= mode_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      first_r     <= first_nxt;
      lin_ph_r    <= lin_ph_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      qv_r        <= qv_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
      s1_v_r      <= iss_v;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
    end
    out_item_r <= out_item_nxt;
  end

  // stage 1 operand selection; quantities not written since a clear read as zero
  logic signed [31:0] qa_val, qb_val, coef, x_op, y_op;
  logic signed [63:0] p1;
  always_comb begin
    qa_val = qv_r[s1_qa_r] ? $signed(qa_rd) : 32'sd0;
    qb_val = qv_r[s1_qb_r] ? $signed(qb_rd) : 32'sd0;
    case (s1_csel_r)
      CS_OFF:  coef = offset_r;
      CS_LIN:  coef = $signed(lin_rd);
      default: coef = $signed(quad_rd);
    endcase
    if (s1_zero_r) begin
      coef = 32'sd0;
    end
    x_op = s1_xqa_r ? qa_val : ONE;
    case (s1_ysel_r)
      YS_QB:   y_op = qb_val;
      YS_TWO:  y_op = TWO;
      default: y_op = ONE;
    endcase
    p1 = coef * x_op;
  end

  logic signed [127:0] ph_x, pl_x;
  assign ph_x = ph_r;
  assign pl_x = pl_r;

  // advance the multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    s1_csel_r <= iss_csel;
    s1_xqa_r  <= iss_xqa;
    s1_ysel_r <= iss_ysel;
    s1_zero_r <= iss_zero;
    s1_qa_r   <= qa_ra;
    s1_qb_r   <= qb_ra;
    p1_r      <= p1;
    y_r       <= y_op;
    pl_r      <= $signed({1'b0, p1_r[31:0]}) * y_r;
    ph_r      <= $signed(p1_r[63:32]) * y_r;
    term_r    <= (ph_x <<< 32) + pl_x;
    if (acc_clr) begin
      acc_r <= '0;
    end else if (s4_v_r) begin
      acc_r <= acc_r + term_r;
    end
    if (state_r == ST_ROUND) begin
      sum_r <= acc_r + HALF;
    end
  end

endmodule
